### src/adaptive_spike_detector_defines.svh
// ----------------------------------------------------------------------------
// Adaptive spike detector assertion macros
// Concurrent assertion wrappers on i_clk (ASD_ASSERT also disabled in i_rst_n reset); empty under NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef ADAPTIVE_SPIKE_DETECTOR_DEFINES_SVH
`define ADAPTIVE_SPIKE_DETECTOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define ASD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define ASD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define ASD_ASSERT(label, prop, msg)
`define ASD_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

### src/asd_pkg.sv
// ----------------------------------------------------------------------------
// Adaptive spike detector package
// Shared types, register map and reset constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package asd_pkg;

    localparam int SAMPLE_BITS_DEF = 24;

    localparam int MARKER_BITS = 16;
    localparam int REFR_BITS   = 12;
    localparam int RATIO_BITS  = 12;
    localparam int DECAY_BITS  = 16;

    localparam int APB_ADDR_BITS = 4;
    localparam int APB_DATA_BITS = 32;

    localparam logic [1:0] REG_MARKER = 2'd0;
    localparam logic [1:0] REG_REFR   = 2'd1;
    localparam logic [1:0] REG_RATIO  = 2'd2;
    localparam logic [1:0] REG_DECAY  = 2'd3;

    localparam logic [MARKER_BITS-1:0] MARKER_RST = 16'd1;
    localparam logic [REFR_BITS-1:0]   REFR_RST   = 12'd240;
    localparam logic [RATIO_BITS-1:0]  RATIO_RST  = 12'd128;
    localparam logic [DECAY_BITS-1:0]  DECAY_RST  = 16'd63627;

    typedef struct packed {
        logic [MARKER_BITS-1:0] spike_marker;
        logic [REFR_BITS-1:0]   refractory_samples;
        logic [RATIO_BITS-1:0]  ratio_q8;
        logic [DECAY_BITS-1:0]  decay_q16;
    } t_cfg;

endpackage

### src/asd_cfg.sv
// ----------------------------------------------------------------------------
// Adaptive spike detector configuration registers
// APB register file holding marker, refractory length, ratio and decay.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module asd_cfg import asd_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready,
    output t_cfg                     o_cfg
);

    t_cfg       r_cfg;
    logic       w_wr;
    logic [1:0] w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign w_idx  = paddr[APB_ADDR_BITS-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.spike_marker       <= MARKER_RST;
            r_cfg.refractory_samples <= REFR_RST;
            r_cfg.ratio_q8           <= RATIO_RST;
            r_cfg.decay_q16          <= DECAY_RST;
        end else if (w_wr) begin
            case (w_idx)
                REG_MARKER: r_cfg.spike_marker       <= pwdata[MARKER_BITS-1:0];
                REG_REFR:   r_cfg.refractory_samples <= pwdata[REFR_BITS-1:0];
                REG_RATIO:  r_cfg.ratio_q8           <= pwdata[RATIO_BITS-1:0];
                REG_DECAY:  r_cfg.decay_q16          <= pwdata[DECAY_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_MARKER: prdata = APB_DATA_BITS'(r_cfg.spike_marker);
            REG_REFR:   prdata = APB_DATA_BITS'(r_cfg.refractory_samples);
            REG_RATIO:  prdata = APB_DATA_BITS'(r_cfg.ratio_q8);
            REG_DECAY:  prdata = APB_DATA_BITS'(r_cfg.decay_q16);
            default:    prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

### src/asd_core.sv
// ----------------------------------------------------------------------------
// Adaptive spike detector core
// Detection state and the combinational judge of the held sample.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "adaptive_spike_detector_defines.svh"

module asd_core import asd_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic signed [SAMPLE_BITS-1:0] i_threshold,
    input  logic                          i_start,
    input  t_cfg                          i_cfg,
    output logic                          o_emit,
    output logic                          o_spike
);

    localparam int CW = SAMPLE_BITS + 2;
    localparam int PW = SAMPLE_BITS + 13;
    localparam int DW = SAMPLE_BITS + DECAY_BITS;

    logic signed [SAMPLE_BITS-1:0] r_held_s, n_held_s;
    logic signed [SAMPLE_BITS-1:0] r_held_t, n_held_t;
    logic                          r_have_held, n_have_held;
    logic                          r_searching, n_searching;
    logic [REFR_BITS-1:0]          r_skip_left, n_skip_left;
    logic signed [SAMPLE_BITS-1:0] r_last_amp, n_last_amp;

    logic signed [CW-1:0]          w_s2, w_t3;
    logic signed [PW-1:0]          w_ls, w_lr;
    logic                          w_cand, w_amp_ok, w_hit, w_neg;
    logic [SAMPLE_BITS-1:0]        w_mag, w_dmag;
    logic [DW-1:0]                 w_dprod;
    logic signed [SAMPLE_BITS-1:0] w_decayed;

    // 2*s > 3*t and s > next
    assign w_s2   = {r_held_s[SAMPLE_BITS-1], r_held_s, 1'b0};
    assign w_t3   = {{2{r_held_t[SAMPLE_BITS-1]}}, r_held_t}
                  + {r_held_t[SAMPLE_BITS-1], r_held_t, 1'b0};
    assign w_cand = (w_s2 > w_t3) && (r_held_s > i_sample);

    // 256*s > ratio*amp
    assign w_ls     = {{5{r_held_s[SAMPLE_BITS-1]}}, r_held_s, 8'b0};
    assign w_lr     = PW'(r_last_amp) * PW'($signed({1'b0, i_cfg.ratio_q8}));
    assign w_amp_ok = (r_last_amp == '0) || (w_ls > w_lr);

    // magnitude decay, sign kept
    assign w_neg     = r_last_amp[SAMPLE_BITS-1];
    assign w_mag     = w_neg ? (SAMPLE_BITS'(0) - r_last_amp) : r_last_amp;
    assign w_dprod   = DW'(w_mag) * DW'(i_cfg.decay_q16);
    assign w_dmag    = w_dprod[DW-1:DECAY_BITS];
    assign w_decayed = w_neg ? (SAMPLE_BITS'(0) - w_dmag) : w_dmag;

    assign w_hit = !i_start && r_have_held && (r_skip_left == '0) && r_searching
                && w_cand && w_amp_ok;

    always_comb begin
        n_searching = r_searching;
        n_skip_left = r_skip_left;
        n_last_amp  = r_last_amp;
        if (i_start) begin
            n_searching = 1'b1;
            n_skip_left = '0;
            n_last_amp  = '0;
        end else if (r_have_held) begin
            if (r_skip_left != '0) begin
                n_skip_left = r_skip_left - 1'b1;
            end else if (!r_searching) begin
                if (r_held_s < r_held_t) begin
                    n_searching = 1'b1;
                end
            end else if (w_cand) begin
                if (w_amp_ok) begin
                    n_last_amp  = r_held_s;
                    n_searching = 1'b0;
                    n_skip_left = i_cfg.refractory_samples;
                end else begin
                    n_last_amp = w_decayed;
                end
            end
        end
        n_held_s    = i_sample;
        n_held_t    = i_threshold;
        n_have_held = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_s    <= '0;
            r_held_t    <= '0;
            r_have_held <= 1'b0;
            r_searching <= 1'b1;
            r_skip_left <= '0;
            r_last_amp  <= '0;
        end else if (i_step) begin
            r_held_s    <= n_held_s;
            r_held_t    <= n_held_t;
            r_have_held <= n_have_held;
            r_searching <= n_searching;
            r_skip_left <= n_skip_left;
            r_last_amp  <= n_last_amp;
        end
    end

    assign o_emit  = r_have_held;
    assign o_spike = w_hit;

    `ASD_ASSERT(a_skip_not_searching, (r_skip_left != '0) |-> !r_searching, "refractory while searching")
    `ASD_ASSERT(a_spike_arms_refr, (i_step && w_hit) |=> (!r_searching && r_last_amp == $past(r_held_s)), "spike did not update state")

endmodule

### src/adaptive_spike_detector.sv
// ----------------------------------------------------------------------------
// Adaptive spike detector
// Delayed-decision spike marker with adaptive amplitude gate and refractory.
// ----------------------------------------------------------------------------
// Result path: a sample's result is loaded into the output register when the
//   following item steps out of the input register (input -> held -> result register).
// Throughput: one item per cycle while m_axis_tready does not stall the output; the judge is combinational.
// Reset: synchronous active low; state cleared, registers to defaults.
`timescale 1ns / 1ps
`include "adaptive_spike_detector_defines.svh"

module adaptive_spike_detector import asd_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // [SB-1:0] sample_value, [2*SB-1:SB] threshold_value, zero pad above
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
    // [0] record_start
    input  logic                     s_axis_tuser,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // [15:0] marker_out
    output logic [MARKER_BITS-1:0]   m_axis_tdata,
    // [0] spike_found
    output logic                     m_axis_tuser,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    t_cfg                          w_cfg;
    logic                          r_in_valid;
    logic signed [SAMPLE_BITS-1:0] r_in_s, r_in_t;
    logic                          r_in_start;
    logic                          r_out_valid;
    logic [MARKER_BITS-1:0]        r_out_marker;
    logic                          r_out_spike;
    logic                          w_advance, w_emit, w_spike;

    asd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_s     <= s_axis_tdata[SAMPLE_BITS-1:0];
            r_in_t     <= s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
            r_in_start <= s_axis_tuser;
        end
    end

    asd_core #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_advance),
        .i_sample    (r_in_s),
        .i_threshold (r_in_t),
        .i_start     (r_in_start),
        .i_cfg       (w_cfg),
        .o_emit      (w_emit),
        .o_spike     (w_spike)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= w_emit;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_emit) begin
            r_out_marker <= w_spike ? w_cfg.spike_marker : '0;
            r_out_spike  <= w_spike;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_marker;
    assign m_axis_tuser  = r_out_spike;

    `ASD_ASSERT(a_no_marker, (r_out_valid && !r_out_spike) |-> r_out_marker == '0, "stray marker")
    `ASD_ASSERT(a_out_from_step, $rose(r_out_valid) |-> $past(w_advance), "result without step")
    `ASD_ASSERT_ALWAYS(a_stall_has_item, !s_axis_tready |-> r_in_valid, "stall while empty")

endmodule

### dv/tb_adaptive_spike_detector.sv
// ----------------------------------------------------------------------------
// Adaptive spike detector testbench
// Streams samples through the detector under random source and sink stalls,
// predicts each delayed spike decision in a local model of the detector, and
// compares every result item field by field. Register writes go over APB
// between traffic phases and are read back. The run covers reset defaults,
// both register extremes and random settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_adaptive_spike_detector;
    import asd_pkg::*;

    localparam int SB          = SAMPLE_BITS_DEF;
    localparam int TDW         = ((2 * SB + 7) / 8) * 8;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 190;
    localparam int SETTLE      = 4;

    typedef struct packed {
        int                     smp;
        int                     thr;
        logic                   start;
        logic                   typed;
        logic [MARKER_BITS-1:0] mk;
        logic                   hit;
    } stim_row_t;

    typedef struct packed {
        logic [MARKER_BITS-1:0] mk;
        logic                   hit;
    } mark_t;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      s_axis_tvalid;
    logic                      s_axis_tready;
    // [23:0] sample_value, [47:24] threshold_value
    logic [TDW-1:0]            s_axis_tdata;
    // [0] record_start
    logic                      s_axis_tuser;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready;
    // [15:0] marker_out
    logic [MARKER_BITS-1:0]    m_axis_tdata;
    // [0] spike_found
    logic                      m_axis_tuser;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [APB_ADDR_BITS-1:0]  paddr;
    logic [APB_DATA_BITS-1:0]  pwdata;
    logic [APB_DATA_BITS-1:0]  prdata;
    logic                      pready;

    // detector model state
    logic [MARKER_BITS-1:0]    cfg_marker = MARKER_RST;
    logic [REFR_BITS-1:0]      cfg_refr   = REFR_RST;
    logic [RATIO_BITS-1:0]     cfg_ratio  = RATIO_RST;
    logic [DECAY_BITS-1:0]     cfg_decay  = DECAY_RST;
    logic signed [SB-1:0]      held_smp   = '0;
    logic signed [SB-1:0]      held_thr   = '0;
    bit                        have_held  = 1'b0;
    bit                        armed      = 1'b1;
    logic [REFR_BITS-1:0]      refr_left  = '0;
    longint                    peak_amp   = 0;

    mark_t                     pending_marks[$];
    int                        send_idle_pct;
    int                        recv_idle_pct;
    int                        mismatches    = 0;
    int                        results_seen  = 0;
    int                        spikes_seen   = 0;
    int                        samples_sent  = 0;
    int                        records_sent  = 0;
    int                        settings_used = 1;
    int                        cycle_cnt     = 0;
    int                        rec_left      = 0;
    int                        rec_thr       = 100;

    stim_row_t dir_rows [23] = '{
        '{0,        0,        1'b1, 1'b0, 16'h0000, 1'b0},
        '{8388607,  0,        1'b0, 1'b1, 16'h0000, 1'b0},
        '{0,        0,        1'b0, 1'b1, 16'hFFFF, 1'b1},
        '{-8388608, 8388607,  1'b0, 1'b0, 16'h0000, 1'b0},
        '{5,        -8388608, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{100,      10,       1'b0, 1'b0, 16'h0000, 1'b0},
        '{0,        0,        1'b0, 1'b0, 16'h0000, 1'b0},
        '{50,       100,      1'b0, 1'b0, 16'h0000, 1'b0},
        '{60,       0,        1'b0, 1'b0, 16'h0000, 1'b0},
        '{10,       0,        1'b0, 1'b0, 16'h0000, 1'b0},
        '{3,        2,        1'b0, 1'b0, 16'h0000, 1'b0},
        '{3,        2,        1'b0, 1'b0, 16'h0000, 1'b0},
        '{4,        2,        1'b0, 1'b0, 16'h0000, 1'b0},
        '{4,        2,        1'b0, 1'b0, 16'h0000, 1'b0},
        '{-8388608, -8388608, 1'b1, 1'b1, 16'h0000, 1'b0},
        '{-8388608, -8388608, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{-100,     -100,     1'b0, 1'b0, 16'h0000, 1'b0},
        '{-200,     0,        1'b0, 1'b1, 16'hFFFF, 1'b1},
        '{0,        0,        1'b0, 1'b0, 16'h0000, 1'b0},
        '{-5,       0,        1'b0, 1'b0, 16'h0000, 1'b0},
        '{-50,      -100,     1'b0, 1'b0, 16'h0000, 1'b0},
        '{-60,      0,        1'b0, 1'b0, 16'h0000, 1'b0},
        '{0,        0,        1'b0, 1'b0, 16'h0000, 1'b0}
    };

    adaptive_spike_detector #(
        .SAMPLE_BITS(SB)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_cnt);
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Decision for the held sample, made when the next sample arrives.
    function automatic bit detector_step(input logic signed [SB-1:0] smp,
                                         input logic signed [SB-1:0] thr,
                                         input bit start,
                                         output logic [MARKER_BITS-1:0] mk,
                                         output bit hit);
        longint hs;
        longint ht;
        longint nx;
        longint mag;
        bit     has;
        hs  = held_smp;
        ht  = held_thr;
        nx  = smp;
        mk  = '0;
        hit = 1'b0;
        has = 1'b0;
        if (start) begin
            has       = have_held;
            armed     = 1'b1;
            refr_left = '0;
            peak_amp  = 0;
        end else if (have_held) begin
            has = 1'b1;
            if (refr_left != 0) begin
                refr_left = refr_left - 1'b1;
            end else if (!armed) begin
                if (hs < ht) armed = 1'b1;
            end else if (2 * hs > 3 * ht && hs > nx) begin
                if (peak_amp == 0 || hs * 256 > peak_amp * longint'(cfg_ratio)) begin
                    peak_amp  = hs;
                    armed     = 1'b0;
                    refr_left = cfg_refr;
                    hit       = 1'b1;
                    mk        = cfg_marker;
                end else begin
                    mag      = (peak_amp < 0) ? -peak_amp : peak_amp;
                    mag      = (mag * longint'(cfg_decay)) >> 16;
                    peak_amp = (peak_amp < 0) ? -mag : mag;
                end
            end
        end
        held_smp  = smp;
        held_thr  = thr;
        have_held = 1'b1;
        return has;
    endfunction

    always @(posedge i_clk) begin : out_check
        mark_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_marks.size() == 0) begin
                if (mismatches < 200)
                    $display("%0t: result with none expected: marker %h spike %b",
                             $time, m_axis_tdata, m_axis_tuser);
                mismatches++;
            end else begin
                want = pending_marks.pop_front();
                results_seen++;
                if (m_axis_tuser === 1'b1) spikes_seen++;
                if (m_axis_tdata !== want.mk) begin
                    if (mismatches < 200)
                        $display("%0t: marker expected %h actual %h",
                                 $time, want.mk, m_axis_tdata);
                    mismatches++;
                end
                if (m_axis_tuser !== want.hit) begin
                    if (mismatches < 200)
                        $display("%0t: spike flag expected %b actual %b",
                                 $time, want.hit, m_axis_tuser);
                    mismatches++;
                end
            end
        end
    end

    task automatic read_reg(input logic [1:0] idx, input logic [APB_DATA_BITS-1:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== want) begin
            $display("%0t: register %0d expected %h actual %h", $time, idx, want, prdata);
            mismatches++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [APB_DATA_BITS-1:0] val);
        logic [APB_DATA_BITS-1:0] kept;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_MARKER: cfg_marker = val[MARKER_BITS-1:0];
            REG_REFR:   cfg_refr   = val[REFR_BITS-1:0];
            REG_RATIO:  cfg_ratio  = val[RATIO_BITS-1:0];
            REG_DECAY:  cfg_decay  = val[DECAY_BITS-1:0];
            default:    ;
        endcase
        case (idx)
            REG_MARKER: kept = APB_DATA_BITS'(cfg_marker);
            REG_REFR:   kept = APB_DATA_BITS'(cfg_refr);
            REG_RATIO:  kept = APB_DATA_BITS'(cfg_ratio);
            default:    kept = APB_DATA_BITS'(cfg_decay);
        endcase
        @(posedge i_clk);
        read_reg(idx, kept);
    endtask

    task automatic apply_setting(input t_cfg c);
        write_reg(REG_MARKER, APB_DATA_BITS'(c.spike_marker));
        write_reg(REG_REFR,   APB_DATA_BITS'(c.refractory_samples));
        write_reg(REG_RATIO,  APB_DATA_BITS'(c.ratio_q8));
        write_reg(REG_DECAY,  APB_DATA_BITS'(c.decay_q16));
        settings_used++;
    endtask

    task automatic send_sample(input logic signed [SB-1:0] smp,
                               input logic signed [SB-1:0] thr,
                               input bit start, input bit typed,
                               input logic [MARKER_BITS-1:0] typed_mk, input bit typed_hit);
        logic [MARKER_BITS-1:0] p_mk;
        bit                     p_hit;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= TDW'({thr, smp});
        s_axis_tuser  <= start;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        samples_sent++;
        if (start) records_sent++;
        if (detector_step(smp, thr, start, p_mk, p_hit)) begin
            if (typed) pending_marks.push_back('{typed_mk, typed_hit});
            else pending_marks.push_back('{p_mk, p_hit});
        end
    endtask

    // Called right after an accepted item; waits out every pending result.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_marks.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Records of peaks over a steady threshold, with some raw noise mixed in.
    task automatic make_random_item(output logic signed [SB-1:0] smp,
                                    output logic signed [SB-1:0] thr, output bit start);
        int pick;
        int t_i;
        int s_i;
        start = 1'b0;
        if (rec_left == 0) begin
            start    = 1'b1;
            rec_left = $urandom_range(8, 300);
            rec_thr  = $urandom_range(16, 20000);
        end
        rec_left--;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            smp = SB'($urandom);
            thr = SB'($urandom);
            if ($urandom_range(0, 39) == 0) start = 1'b1;
        end else begin
            t_i = rec_thr + int'($urandom_range(0, 64)) - 32;
            if (pick < 20)
                s_i = t_i + t_i / 2 + int'($urandom_range(1, 2 * rec_thr));
            else if (pick < 50)
                s_i = int'($urandom_range(0, rec_thr)) - 40;
            else
                s_i = int'($urandom_range(0, 2 * rec_thr));
            smp = SB'(s_i);
            thr = SB'(t_i);
        end
    endtask

    initial begin
        t_cfg                 phase_cfg [6];
        logic signed [SB-1:0] smp;
        logic signed [SB-1:0] thr;
        bit                   start;
        phase_cfg[0] = '{16'h0000, 12'd0, 12'd0, 16'd0};
        phase_cfg[1] = '{16'hFFFF, 12'd4095, 12'd4095, 16'hFFFF};
        phase_cfg[2] = '{MARKER_RST, REFR_RST, RATIO_RST, DECAY_RST};
        phase_cfg[3] = '{16'hA5C3, 12'd3, 12'd256, 16'd32768};
        phase_cfg[4] = '{16'h5A3C, 12'd7, 12'd64, 16'd65000};
        phase_cfg[5].spike_marker       = MARKER_BITS'($urandom);
        phase_cfg[5].refractory_samples = REFR_BITS'($urandom_range(0, 20));
        phase_cfg[5].ratio_q8           = RATIO_BITS'($urandom_range(0, 4095));
        phase_cfg[5].decay_q16          = DECAY_BITS'($urandom);

        send_idle_pct = 7;
        recv_idle_pct = 49;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        read_reg(REG_MARKER, APB_DATA_BITS'(MARKER_RST));
        read_reg(REG_REFR,   APB_DATA_BITS'(REFR_RST));
        read_reg(REG_RATIO,  APB_DATA_BITS'(RATIO_RST));
        read_reg(REG_DECAY,  APB_DATA_BITS'(DECAY_RST));

        // short refractory so the directed rows reach the re-arm path
        write_reg(REG_MARKER, 32'h0000_FFFF);
        write_reg(REG_REFR,   32'd2);
        foreach (dir_rows[i])
            send_sample(SB'(dir_rows[i].smp), SB'(dir_rows[i].thr), dir_rows[i].start,
                        dir_rows[i].typed, dir_rows[i].mk, dir_rows[i].hit);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph / 2)
                0: begin send_idle_pct = 7;  recv_idle_pct = 49; end
                1: begin send_idle_pct = 49; recv_idle_pct = 7;  end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            apply_setting(phase_cfg[ph]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n == PHASE_ITEMS / 2) drain();
                make_random_item(smp, thr, start);
                send_sample(smp, thr, start, 1'b0, '0, 1'b0);
            end
            drain();
        end

        $display("Sent %0d samples in %0d records over %0d register settings;",
                 samples_sent, records_sent, settings_used);
        $display("checked %0d results, %0d of them spikes, %0d left unmatched.",
                 results_seen, spikes_seen, pending_marks.size());
        if (mismatches == 0 && pending_marks.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+src
src/asd_pkg.sv
src/asd_cfg.sv
src/asd_core.sv
src/adaptive_spike_detector.sv
dv/tb_adaptive_spike_detector.sv
